// ----- src/iol_pkg.sv -----
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types, codes and field widths of the indexed ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package iol_pkg;

  // Field widths of the request and response beats
  localparam int unsigned OP_W          = 2;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned READ_W        = 32;
  localparam int unsigned COUNT_FIELD_W = 5;

  // Defaults of the top-level parameters
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BOUNDS = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_READ,
    ST_READ_DATA,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;   // latch request, checks and cursor
    logic shift_rd;   // read the neighbor of the cursor
    logic shift_wr;   // write the word just read at the cursor, step cursor
    logic put_value;  // write the new word at the insert position
    logic read_pos;   // read the entry at the request position
    logic capture;    // latch the read word into the result
    logic finish;     // commit count and load the response register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_reject; // incoming request fails its position or full check
    op_e  req_op;     // op of the incoming request
    op_e  cur_op;     // op of the request in progress
    logic more;       // entries still to move
    logic out_free;   // response register can take a beat this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/iol_if.sv -----
// ----------------------------------------------------------------------------
// iol_req_if / iol_rsp_if
// Valid/ready channels that carry list requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface iol_req_if import iol_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [READ_W-1:0]        read_value;
  logic [COUNT_FIELD_W-1:0] count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

`default_nettype wire

// ----- src/iol_ram.sv -----
// ----------------------------------------------------------------------------
// iol_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/iol_ctrl.sv -----
// ----------------------------------------------------------------------------
// iol_ctrl
// Sequencer of the list: accepts a request, walks the shift loop, reads,
// and hands the result to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_ctrl import iol_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.req_reject || status_i.req_op == OP_CLEAR) begin
            state_d = ST_FINISH;
          end else if (status_i.req_op == OP_READ) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_SHIFT_RD;
          end
        end
      end
      ST_SHIFT_RD: begin
        state_d = status_i.more ? ST_SHIFT_WR : ST_FINISH;
      end
      ST_SHIFT_WR:  state_d = ST_SHIFT_RD;
      ST_READ:      state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = accept;
      end
      ST_SHIFT_RD: begin
        cmd_o.shift_rd  = status_i.more;
        cmd_o.put_value = !status_i.more && (status_i.cur_op == OP_INSERT);
      end
      ST_SHIFT_WR:  cmd_o.shift_wr = 1'b1;
      ST_READ:      cmd_o.read_pos = 1'b1;
      ST_READ_DATA: cmd_o.capture  = 1'b1;
      ST_FINISH:    cmd_o.finish   = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/iol_dp.sv -----
// ----------------------------------------------------------------------------
// iol_dp
// Datapath of the list: entry RAM, count, cursor, request checks and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_dp import iol_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic [VALUE_W-1:0]       value_i,
  input  wire dp_cmd_t                  cmd_i,
  output dp_status_t                    status_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [STATUS_W-1:0]      out_status_o,
  output logic      [READ_W-1:0]        out_read_value_o,
  output logic      [COUNT_FIELD_W-1:0] out_count_o
);

  localparam int unsigned AW      = $clog2(CAPACITY);
  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  logic [COUNT_W-1:0]    count_q, count_d;
  logic [AW-1:0]         cursor_q, cursor_d;
  op_e                   op_q;
  logic [AW-1:0]         pos_q;
  logic [DATA_WIDTH-1:0] value_q;
  status_e               status_q, req_status;
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [READ_W-1:0]     out_read_q;
  logic [COUNT_FIELD_W-1:0] out_count_q;

  op_e                   req_op;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic                  more;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // Request checks against the current count
  assign req_op  = op_e'(op_i);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    req_status = STATUS_OK;
    case (req_op)
      OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          req_status = STATUS_BOUNDS;
        end else if (count_q == COUNT_W'(CAPACITY)) begin
          req_status = STATUS_FULL;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          req_status = STATUS_BOUNDS;
        end
      end
      default: req_status = STATUS_OK;
    endcase
  end

  // Insert walks the cursor down from the end, remove walks it up
  always_comb begin
    if (op_q == OP_INSERT) begin
      more = cursor_q > pos_q;
    end else begin
      more = (COUNT_W'(cursor_q) + COUNT_W'(1)) < count_q;
    end
  end

  assign status_o.req_reject = (req_status != STATUS_OK);
  assign status_o.req_op     = req_op;
  assign status_o.cur_op     = op_q;
  assign status_o.more       = more;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Cursor
  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.load_req) begin
      cursor_d = (req_op == OP_INSERT) ? AW'(count_q) : AW'(position_i);
    end else if (cmd_i.shift_wr) begin
      cursor_d = (op_q == OP_INSERT) ? cursor_q - AW'(1) : cursor_q + AW'(1);
    end
  end

  // RAM port selection
  always_comb begin
    ram_re    = cmd_i.shift_rd || cmd_i.read_pos;
    ram_raddr = pos_q;
    if (cmd_i.shift_rd) begin
      ram_raddr = (op_q == OP_INSERT) ? cursor_q - AW'(1) : cursor_q + AW'(1);
    end
    ram_we    = cmd_i.shift_wr || cmd_i.put_value;
    ram_waddr = cmd_i.shift_wr ? cursor_q : pos_q;
    ram_wdata = cmd_i.shift_wr ? ram_rdata : value_q;
  end

  iol_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Count after the operation in progress
  always_comb begin
    count_d = count_q;
    if (status_q == STATUS_OK) begin
      case (op_q)
        OP_INSERT: count_d = count_q + COUNT_W'(1);
        OP_REMOVE: count_d = count_q - COUNT_W'(1);
        OP_CLEAR:  count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    if (cmd_i.load_req) begin
      op_q     <= req_op;
      pos_q    <= AW'(position_i);
      value_q  <= DATA_WIDTH'(value_i);
      status_q <= req_status;
      rd_q     <= '0;
    end
    if (cmd_i.capture) begin
      rd_q <= ram_rdata;
    end
    if (cmd_i.finish) begin
      out_status_q <= status_q;
      out_read_q   <= READ_W'(rd_q);
      out_count_q  <= COUNT_FIELD_W'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_read_value_o = out_read_q;
  assign out_count_o      = out_count_q;

endmodule

`default_nettype wire

// ----- src/indexed_ordered_list_core.sv -----
// ----------------------------------------------------------------------------
// indexed_ordered_list_core
// Ordered list of up to CAPACITY words addressed by position.
//
// Requests arrive on req_i (op, position, value), one response per request
// leaves on rsp_o (status, read_value, count). A beat moves when valid and
// ready are both high.
// One request is in work at a time; req_i.ready is high only while idle,
// so no new request is taken before the last one has committed. A clear
// or a rejected request goes straight to the final state; a read reads the
// entry RAM, captures the word, then finishes; insert and remove walk the
// shift loop, where each moved entry takes one RAM read and one RAM write
// through the single entry RAM, and then finish.
// The response sits in an output register, so the next request is taken
// while a response waits. If rsp_o stalls, the next operation stops in
// its final state until the register frees; then it commits.
// Reset empties the list and drops any pending response at once; the
// entry RAM keeps its contents, which are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_ordered_list_core import iol_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iol_req_if.sink    req_i,
  iol_rsp_if.source  rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequencer: accepts a request, runs the shift or read, then commits
  iol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: entry RAM, count, cursor and the response register
  iol_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (req_i.op),
    .position_i       (req_i.position),
    .value_i          (req_i.value),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .out_status_o     (rsp_o.status),
    .out_read_value_o (rsp_o.read_value),
    .out_count_o      (rsp_o.count)
  );

  assign req_i.ready = in_ready;

endmodule

`default_nettype wire
